// File: hdl/retry_backoff_timer_assert.svh
// ----------------------------------------------------------------------------
// Retry backoff timer assertion macros
// Concurrent assertion wrappers for the retry backoff timer; empty in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RETRY_BACKOFF_TIMER_ASSERT_SVH
`define RETRY_BACKOFF_TIMER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define RBT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RBT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RBT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RBT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: hdl/rbt_pkg.sv
// ----------------------------------------------------------------------------
// Retry backoff timer package
// Word types, request and event codes, and the timer mode encoding.
// ----------------------------------------------------------------------------
package rbt_pkg;

    localparam int DEFAULT_MAX_INTERVALS = 8;
    localparam int INTERVAL_W            = 32;

    // Request codes
    localparam logic [2:0] ACT_APPEND    = 3'd0;
    localparam logic [2:0] ACT_START     = 3'd1;
    localparam logic [2:0] ACT_RESUME    = 3'd2;
    localparam logic [2:0] ACT_TERMINATE = 3'd3;
    localparam logic [2:0] ACT_TICK      = 3'd4;

    // Interim-expiry decision codes (anything else means stop)
    localparam logic [1:0] DEC_CONTINUE = 2'd0;
    localparam logic [1:0] DEC_PENDING  = 2'd1;

    // Expiry event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_INTERIM = 2'd1;
    localparam logic [1:0] EV_FINAL   = 2'd2;

    // Reported timer state codes
    localparam logic [1:0] TS_INACTIVE = 2'd0;
    localparam logic [1:0] TS_ACTIVE   = 2'd1;
    localparam logic [1:0] TS_PENDING  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_REPEATABLE = 1'b0;
    localparam logic CFG_LISTENER   = 1'b1;

    typedef enum logic [2:0] {
        MODE_INACTIVE = 3'b001,
        MODE_ACTIVE   = 3'b010,
        MODE_PENDING  = 3'b100
    } mode_t;

    typedef struct packed {
        logic [2:0]            action;
        logic [INTERVAL_W-1:0] interval_ms;
        logic [1:0]            decision;
    } req_t;

    typedef struct packed {
        logic                  accepted;
        logic [1:0]            expiry_event;
        logic [1:0]            timer_state;
        logic [INTERVAL_W-1:0] next_interval;
    } rsp_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] code;
        case (m)
            MODE_ACTIVE:  code = TS_ACTIVE;
            MODE_PENDING: code = TS_PENDING;
            default:      code = TS_INACTIVE;
        endcase
        return code;
    endfunction

endpackage

// File: hdl/retry_backoff_timer.sv
// ----------------------------------------------------------------------------
// Retry backoff timer
// Retry timer that walks a schedule of millisecond intervals.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one request word per handshake (append, start, resume,
//   terminate or millisecond tick). A word is taken at a clock edge with
//   req_valid high and req_stall low.
//   rsp channel: exactly one response word per request, in order, taken at
//   an edge with rsp_valid high and rsp_stall low.
//   cfg channel: writes repeatable (index 0) and listener_enabled (index 1);
//   cfg_ready is always high. Write only while the block is idle.
//   The response is registered: the response to a request taken at an
//   edge is valid after that edge. Throughput is one request per cycle
//   while rsp_stall is low; the response register is the only stage and a
//   new request enters in the cycle the previous response leaves.
//   The schedule table is a memory with one write and one registered read
//   port; the read tracks the entry at the tracker index so the head
//   interval is ready for the next request.
//   Reset clears the mode, counters, remaining time and configuration; the
//   table itself is not cleared, entries are only read below the count.
//   While rsp_stall holds a pending response, req_stall is raised and the
//   timer state does not move.
// ----------------------------------------------------------------------------
`include "retry_backoff_timer_assert.svh"

module retry_backoff_timer #(
    parameter int MAX_INTERVALS = rbt_pkg::DEFAULT_MAX_INTERVALS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_stall,
    input  rbt_pkg::req_t req,
    output logic         rsp_valid,
    input  logic         rsp_stall,
    output rbt_pkg::rsp_t rsp,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic         cfg_data
);
    import rbt_pkg::*;

    // Tracker and count reach MAX_INTERVALS itself; addresses stop below it.
    localparam int TW = $clog2(MAX_INTERVALS + 1);
    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam logic [TW-1:0] MAX_T = TW'(MAX_INTERVALS);

    // Schedule storage
    logic [INTERVAL_W-1:0] table_mem [MAX_INTERVALS];
    logic [INTERVAL_W-1:0] rd_reg;     // entry at tracker_reg
    logic [INTERVAL_W-1:0] last_reg;   // entry at count_reg - 1

    // Timer state
    mode_t                 mode_reg, mode_next;
    logic [TW-1:0]         count_reg, count_next;
    logic [TW-1:0]         tracker_reg, tracker_next;
    logic [INTERVAL_W-1:0] remaining_reg, remaining_next;
    logic                  repeatable_reg;
    logic                  listener_reg;

    // Response register
    logic                  rsp_valid_reg;
    logic                  acc_reg, acc_next;
    logic [1:0]            ev_reg, ev_next;

    logic                  req_accept;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [INTERVAL_W-1:0] head;
    logic                  exhausted;
    logic [TW-1:0]         arm_idx;
    logic [INTERVAL_W-1:0] arm_val;
    logic [TW-1:0]         arm_idx_inc;

    // ------------------------------------------------------------------
    // Handshake: take a request whenever the response slot is free or
    // draining this cycle.
    // ------------------------------------------------------------------
    assign req_stall  = rsp_valid_reg & rsp_stall;
    assign req_accept = req_valid & ~req_stall;
    assign cfg_ready  = 1'b1;

    // Interval at the tracker index, zero once the schedule is used up.
    assign head = (tracker_reg < count_reg) ? rd_reg : '0;

    // On expiry with the schedule used up in repeatable mode, the tracker
    // falls back to the last entry, which last_reg mirrors.
    assign exhausted   = (tracker_reg >= count_reg);
    assign arm_idx     = exhausted ? (count_reg - TW'(1)) : tracker_reg;
    assign arm_val     = exhausted ? last_reg : head;
    assign arm_idx_inc = (arm_idx < MAX_T) ? (arm_idx + TW'(1)) : arm_idx;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next      = mode_reg;
        count_next     = count_reg;
        tracker_next   = tracker_reg;
        remaining_next = remaining_reg;
        acc_next       = 1'b0;
        ev_next        = EV_NONE;
        wr_en          = 1'b0;

        case (req.action)
            ACT_APPEND:
            begin
                // Refuse while running or when the table is full.
                if (mode_reg != MODE_ACTIVE && count_reg < MAX_T)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + TW'(1);
                    acc_next   = 1'b1;
                end
            end
            ACT_START, ACT_RESUME:
            begin
                if (mode_reg == MODE_ACTIVE)
                begin
                    acc_next = 1'b1;
                end
                else if ((req.action == ACT_START || mode_reg == MODE_PENDING)
                         && count_reg != '0)
                begin
                    // Arm with the head interval and step the tracker.
                    remaining_next = head;
                    tracker_next   = (tracker_reg < MAX_T) ? (tracker_reg + TW'(1))
                                                           : tracker_reg;
                    mode_next      = MODE_ACTIVE;
                    acc_next       = 1'b1;
                end
            end
            ACT_TERMINATE:
            begin
                acc_next = 1'b1;
                if (mode_reg != MODE_INACTIVE)
                begin
                    tracker_next = '0;
                    mode_next    = MODE_INACTIVE;
                end
            end
            ACT_TICK:
            begin
                acc_next = 1'b1;
                if (mode_reg == MODE_ACTIVE)
                begin
                    if (remaining_reg > INTERVAL_W'(1))
                    begin
                        remaining_next = remaining_reg - INTERVAL_W'(1);
                    end
                    else
                    begin
                        remaining_next = '0;
                        if (exhausted && !(repeatable_reg && count_reg != '0))
                        begin
                            // Schedule done: final expiry.
                            tracker_next = '0;
                            mode_next    = MODE_INACTIVE;
                            ev_next      = EV_FINAL;
                        end
                        else
                        begin
                            ev_next      = EV_INTERIM;
                            tracker_next = arm_idx;
                            if (!listener_reg || req.decision == DEC_CONTINUE)
                            begin
                                remaining_next = arm_val;
                                tracker_next   = arm_idx_inc;
                            end
                            else if (req.decision == DEC_PENDING)
                            begin
                                mode_next = MODE_PENDING;
                            end
                            else
                            begin
                                tracker_next = '0;
                                mode_next    = MODE_INACTIVE;
                            end
                        end
                    end
                end
            end
            default:
            begin
                // Unknown request: refuse, change nothing.
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and response registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_INACTIVE;
            count_reg     <= '0;
            tracker_reg   <= '0;
            remaining_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_accept)
            begin
                mode_reg      <= mode_next;
                count_reg     <= count_next;
                tracker_reg   <= tracker_next;
                remaining_reg <= remaining_next;
            end
            // Hold the response while stalled, drop it once taken.
            rsp_valid_reg <= req_accept | (rsp_valid_reg & rsp_stall);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeatable_reg <= 1'b0;
            listener_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_REPEATABLE: repeatable_reg <= cfg_data;
                CFG_LISTENER:   listener_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            acc_reg <= acc_next;
            ev_reg  <= ev_next;
        end
    end

    // ------------------------------------------------------------------
    // Schedule memory: write at the count, read at the next tracker index.
    // Bypass the write when both hit the same entry.
    // ------------------------------------------------------------------
    assign wr_addr = count_reg[AW-1:0];
    assign rd_addr = tracker_next[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (req_accept && wr_en)
        begin
            table_mem[wr_addr] <= req.interval_ms;
            last_reg           <= req.interval_ms;
        end
        if (req_accept)
        begin
            rd_reg <= (wr_en && wr_addr == rd_addr) ? req.interval_ms
                                                    : table_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Response word: state fields come straight from the state registers,
    // which only move together with the response register.
    // ------------------------------------------------------------------
    assign rsp_valid          = rsp_valid_reg;
    assign rsp.accepted       = acc_reg;
    assign rsp.expiry_event   = ev_reg;
    assign rsp.timer_state    = mode_code(mode_reg);
    assign rsp.next_interval  = head;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RBT_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= MAX_T, "interval count overflow")
    `RBT_ASSERT_IMP(a_tracker_bound, clk, rst_n, 1'b1, tracker_reg <= count_reg, "tracker beyond count")
    `RBT_ASSERT_IMP(a_active_nonempty, clk, rst_n, mode_reg == MODE_ACTIVE, count_reg != '0, "active with empty schedule")
    `RBT_ASSERT_IMP(a_final_inactive, clk, rst_n, rsp_valid_reg && ev_reg == EV_FINAL, mode_reg == MODE_INACTIVE && tracker_reg == '0, "final expiry left timer running")

endmodule

// File: tb/retry_backoff_timer_tb.sv
// ----------------------------------------------------------------------------
// Retry backoff timer testbench
// Drives request words with random gaps and response stalls, predicts every
// response word with an in-bench model of the interval schedule and compares
// them in order; walks several register settings between quiet points.
// ----------------------------------------------------------------------------
module retry_backoff_timer_tb;

    import rbt_pkg::*;

    localparam int SCHED_DEPTH = DEFAULT_MAX_INTERVALS;
    localparam int RANDOM_WORDS = 1250;
    localparam int BACKLOG_CYCLES = 64;

    // Decision codes that mean stop, and request codes the block must ignore
    localparam logic [1:0] DEC_STOP     = 2'd2;
    localparam logic [1:0] DEC_STOP_ALT = 2'd3;
    localparam logic [2:0] ACT_BOGUS_LO = 3'd5;
    localparam logic [2:0] ACT_BOGUS_HI = 3'd7;

    // ------------------------------------------------------------------------
    // Schedule tracker: mirrors the timer state and holds the response words
    // still owed by the block, oldest first.
    // ------------------------------------------------------------------------
    class backoff_tracker;
        logic [31:0] sched [SCHED_DEPTH];
        logic [3:0]  count;
        logic [3:0]  trk;
        logic [1:0]  state;
        logic [31:0] left;
        bit          repeat_last;
        bit          use_decision;
        rsp_t        due_replies[$];
        int          mismatches;
        int          requests;
        int          replies;
        int          interims;
        int          finals;
        int          pauses;

        function new();
            count = '0;
            trk = '0;
            state = TS_INACTIVE;
            left = '0;
            repeat_last = 1'b0;
            use_decision = 1'b0;
            mismatches = 0;
            requests = 0;
            replies = 0;
            interims = 0;
            finals = 0;
            pauses = 0;
        endfunction

        function logic [31:0] head_interval();
            if (trk >= count || trk >= SCHED_DEPTH)
                return '0;
            return sched[trk[2:0]];
        endfunction

        // Load the interval under the tracker and advance it
        function void load_next();
            left = head_interval();
            if (trk < SCHED_DEPTH)
                trk++;
        endfunction

        function void take_request(input req_t w);
            rsp_t       r;
            logic       ok;
            logic [1:0] ev;
            ok = 1'b0;
            ev = EV_NONE;
            requests++;
            case (w.action)
                ACT_APPEND:
                begin
                    if (state != TS_ACTIVE && count < SCHED_DEPTH)
                    begin
                        sched[count[2:0]] = w.interval_ms;
                        count++;
                        ok = 1'b1;
                    end
                end
                ACT_START, ACT_RESUME:
                begin
                    if (state == TS_ACTIVE)
                        ok = 1'b1;
                    else if ((w.action == ACT_START || state == TS_PENDING) && count != 0)
                    begin
                        load_next();
                        state = TS_ACTIVE;
                        ok = 1'b1;
                    end
                end
                ACT_TERMINATE:
                begin
                    ok = 1'b1;
                    if (state != TS_INACTIVE)
                    begin
                        trk = '0;
                        state = TS_INACTIVE;
                    end
                end
                ACT_TICK:
                begin
                    ok = 1'b1;
                    if (state == TS_ACTIVE)
                    begin
                        if (left > 1)
                            left--;
                        else
                        begin
                            left = '0;
                            if (trk >= count && !(repeat_last && count != 0))
                            begin
                                // schedule used up and no repeat: final expiry
                                trk = '0;
                                state = TS_INACTIVE;
                                ev = EV_FINAL;
                                finals++;
                            end
                            else
                            begin
                                if (trk >= count)
                                    trk = count - 4'd1;
                                ev = EV_INTERIM;
                                interims++;
                                if (!use_decision || w.decision == DEC_CONTINUE)
                                    load_next();
                                else if (w.decision == DEC_PENDING)
                                begin
                                    state = TS_PENDING;
                                    pauses++;
                                end
                                else
                                begin
                                    trk = '0;
                                    state = TS_INACTIVE;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.accepted = ok;
            r.expiry_event = ev;
            r.timer_state = state;
            r.next_interval = head_interval();
            due_replies.push_back(r);
        endfunction

        function void match_reply(input rsp_t got);
            rsp_t want;
            replies++;
            if (due_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response word %0d arrived with none expected", replies);
                return;
            end
            want = due_replies.pop_front();
            if (got.accepted !== want.accepted || got.expiry_event !== want.expiry_event ||
                got.timer_state !== want.timer_state ||
                got.next_interval !== want.next_interval)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: word %0d exp acc=%0d ev=%0d st=%0d nxt=%0d",
                             replies, want.accepted, want.expiry_event, want.timer_state,
                             want.next_interval);
                    $display("       got acc=%0d ev=%0d st=%0d nxt=%0d",
                             got.accepted, got.expiry_event, got.timer_state, got.next_interval);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic cfg_data = 1'b0;

    backoff_tracker ledger = new();

    bit calm = 1'b0;            // no idling on either side while set
    bit backlog_request = 1'b0; // ask the receiver for one long hold-off
    int hold_left = 0;
    int settings_seen = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    retry_backoff_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Sample both channels at the rising edge; inputs only move at the
    // falling edge, so the values seen here are settled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                ledger.take_request(req);
            if (rsp_valid && !rsp_stall)
                ledger.match_reply(rsp);
        end
    end

    // Receiver: stall about 27 percent of the time, except in a calm stretch.
    // A backlog request holds stall high for a long run of cycles so the
    // response register stays full and the block pushes back on requests.
    always @(negedge clk)
    begin
        if (backlog_request)
        begin
            backlog_request = 1'b0;
            hold_left = BACKLOG_CYCLES;
        end
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else
            rsp_stall <= !calm && ($urandom_range(99) < 27);
    end

    // Give up after a generous fixed time
    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request side helpers
    // ------------------------------------------------------------------------
    function automatic req_t make_req(input logic [2:0] act, input logic [31:0] ival,
                                      input logic [1:0] dec);
        req_t w;
        w.action = act;
        w.interval_ms = ival;
        w.decision = dec;
        return w;
    endfunction

    // Keep accepted intervals short so schedules expire within a sequence;
    // an append that will be refused carries a fully random value.
    function automatic logic [31:0] append_value();
        if (ledger.count < SCHED_DEPTH && ledger.state != TS_ACTIVE)
            return $urandom_range(0, 5);
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_decision();
        int d;
        d = $urandom_range(99);
        if (d < 55)
            return DEC_CONTINUE;
        if (d < 75)
            return DEC_PENDING;
        if (d < 92)
            return DEC_STOP;
        return DEC_STOP_ALT;
    endfunction

    // Offer one word, with random idle cycles first; return at the falling
    // edge after it was taken, valid still high.
    task automatic send_word(input req_t w);
        while (!calm && $urandom_range(99) < 27)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed response has come back, then let
    // the response pipeline settle before returning.
    task automatic quiesce();
        int guard;
        guard = 0;
        req_valid <= 1'b0;
        @(negedge clk);
        while (ledger.due_replies.size() != 0 && guard < 5000)
        begin
            guard++;
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Write both registers back to back, valid held high across the pair
    task automatic write_settings(input logic rep, input logic lis);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_REPEATABLE;
        cfg_data <= rep;
        do @(posedge clk); while (!cfg_ready);
        ledger.repeat_last = rep;
        @(negedge clk);
        cfg_index <= CFG_LISTENER;
        cfg_data <= lis;
        do @(posedge clk); while (!cfg_ready);
        ledger.use_decision = lis;
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_seen++;
    endtask

    // One retry episode: optional clean-up and appends, start, a run of
    // ticks with mixed decisions, resumes out of pending, and some noise.
    task automatic play_sequence();
        int ticks;
        int pick;
        logic [2:0] act;
        if ($urandom_range(99) < 30)
            send_word(make_req(ACT_TERMINATE, $urandom, 2'($urandom_range(0, 3))));
        repeat ($urandom_range(0, 2))
            send_word(make_req(ACT_APPEND, append_value(), 2'($urandom_range(0, 3))));
        send_word(make_req(ACT_START, $urandom, 2'($urandom_range(0, 3))));
        ticks = $urandom_range(1, 24);
        repeat (ticks)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                act = 3'($urandom_range(0, 7));
                send_word(make_req(act, (act == ACT_APPEND) ? append_value() : $urandom,
                                   2'($urandom_range(0, 3))));
            end
            else if (ledger.state == TS_PENDING && pick < 45)
            begin
                if ($urandom_range(1))
                    send_word(make_req(ACT_APPEND, append_value(), 2'($urandom_range(0, 3))));
                send_word(make_req(ACT_RESUME, $urandom, 2'($urandom_range(0, 3))));
            end
            else if (pick < 12)
                send_word(make_req(ACT_RESUME, $urandom, 2'($urandom_range(0, 3))));
            else
                send_word(make_req(ACT_TICK, $urandom, pick_decision()));
        end
        if ($urandom_range(99) < 60)
            send_word(make_req(ACT_TERMINATE, $urandom, 2'($urandom_range(0, 3))));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [1:0] phase_cfg [5];
        int goal;
        phase_cfg[0] = 2'b00;
        phase_cfg[1] = 2'b11;
        phase_cfg[2] = 2'b01;
        phase_cfg[3] = 2'b10;
        phase_cfg[4] = 2'b11;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, no repeat and no listener: empty table, ignored codes,
        // zero interval, a refused append, final expiry.
        write_settings(1'b0, 1'b0);
        send_word(make_req(ACT_START, 32'd0, DEC_CONTINUE));     // empty table
        send_word(make_req(ACT_RESUME, 32'd0, DEC_CONTINUE));    // not pending
        send_word(make_req(ACT_TICK, 32'd0, DEC_CONTINUE));      // idle tick
        send_word(make_req(ACT_TERMINATE, 32'd0, DEC_CONTINUE)); // already idle
        send_word(make_req(ACT_BOGUS_LO, 32'hFFFF_FFFF, DEC_STOP_ALT));
        send_word(make_req(ACT_BOGUS_HI, 32'd0, DEC_CONTINUE));
        send_word(make_req(ACT_APPEND, 32'd0, DEC_CONTINUE));    // zero interval
        send_word(make_req(ACT_START, 32'd0, DEC_CONTINUE));
        send_word(make_req(ACT_APPEND, 32'hFFFF_FFFF, DEC_STOP_ALT)); // refused, active
        send_word(make_req(ACT_START, 32'd0, DEC_CONTINUE));     // start while active
        send_word(make_req(ACT_TICK, 32'd0, DEC_PENDING));       // zero expires: final
        send_word(make_req(ACT_APPEND, 32'd2, DEC_CONTINUE));
        send_word(make_req(ACT_APPEND, 32'd1, DEC_CONTINUE));
        send_word(make_req(ACT_START, 32'd0, DEC_CONTINUE));
        send_word(make_req(ACT_TICK, 32'd0, DEC_STOP));          // listener off: continue
        repeat (3) send_word(make_req(ACT_TICK, 32'd0, DEC_CONTINUE));

        // Directed, repeat and listener on: pending, append while pending,
        // resume, both stop codes, repeat of the last interval.
        quiesce();
        write_settings(1'b1, 1'b1);
        send_word(make_req(ACT_START, 32'd0, DEC_CONTINUE));
        send_word(make_req(ACT_TICK, 32'd0, DEC_PENDING));
        send_word(make_req(ACT_APPEND, 32'd3, DEC_CONTINUE));
        send_word(make_req(ACT_RESUME, 32'd0, DEC_CONTINUE));
        send_word(make_req(ACT_TICK, 32'd0, DEC_CONTINUE));
        send_word(make_req(ACT_TICK, 32'd0, DEC_STOP));
        send_word(make_req(ACT_START, 32'd0, DEC_CONTINUE));
        send_word(make_req(ACT_TICK, 32'd0, DEC_STOP_ALT));
        send_word(make_req(ACT_START, 32'd0, DEC_CONTINUE));
        repeat (7) send_word(make_req(ACT_TICK, 32'd0, DEC_CONTINUE));
        send_word(make_req(ACT_TERMINATE, 32'd0, DEC_CONTINUE));

        // Random episodes over several settings. Phase 1 and 3 open with a
        // long receiver hold-off; phase 2 runs with no idling at all.
        goal = ledger.requests;
        for (int p = 0; p < 5; p++)
        begin
            quiesce();
            write_settings(phase_cfg[p][1], phase_cfg[p][0]);
            calm = (p == 2);
            if (p == 1 || p == 3)
                backlog_request = 1'b1;
            goal += RANDOM_WORDS / 5;
            while (ledger.requests < goal)
                play_sequence();
        end
        calm = 1'b0;
        quiesce();

        if (ledger.due_replies.size() != 0)
        begin
            $display("ERROR: %0d response words never arrived", ledger.due_replies.size());
            ledger.mismatches += ledger.due_replies.size();
        end

        $display("Run covered %0d requests and %0d responses over %0d register settings",
                 ledger.requests, ledger.replies, settings_seen);
        $display("Timer gave %0d interim and %0d final expiries, paused %0d times",
                 ledger.interims, ledger.finals, ledger.pauses);
        if (ledger.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
